// ===== rtl/core/sbot_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the sky box overlap test.
package sbot_pkg;

  localparam int AngW       = 40;
  localparam int XyW        = 34;
  localparam int ZW         = 37;
  localparam int QW         = 43;
  localparam int CordicSteps = 28;
  localparam int DivSteps   = 43;

  localparam logic signed [XyW-1:0] XInit  = 34'sd652032874;
  localparam logic signed [XyW-1:0] OneQ30 = 34'sd1073741824;
  localparam logic signed [31:0]    CosMin = 32'sd262144;
  localparam logic [QW-1:0]         FSat   = 43'h3FFC0000000;
  localparam logic [QW-1:0]         OneQ   = 43'h40000000;
  localparam logic [31:0]           RemInit = 32'h20000;

  localparam logic [ZW-1:0] Deg90  = 37'd90  << 28;
  localparam logic [ZW-1:0] Deg180 = 37'd180 << 28;
  localparam logic [ZW-1:0] Deg360 = 37'd360 << 28;

  // Side data that travels with each point down the pipeline.
  typedef struct packed {
    logic signed [AngW-1:0] pr;
    logic signed [AngW-1:0] base;
    logic signed [AngW-1:0] size;
    logic                   south;
    logic                   dec_ok;
    logic                   last;
    logic                   neg;
    logic                   sat;
    logic [31:0]            fs;
  } pay_t;

  // Arctangent of 2^-i in degrees, 28 fraction bits.
  function automatic logic signed [ZW-1:0] atan_q28(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 37'sd12079595520;
      1:  r = 37'sd7131001626;
      2:  r = 37'sd3767825416;
      3:  r = 37'sd1912607013;
      4:  r = 37'sd960014949;
      5:  r = 37'sd480475470;
      6:  r = 37'sd240296363;
      7:  r = 37'sd120155514;
      8:  r = 37'sd60078674;
      9:  r = 37'sd30039451;
      10: r = 37'sd15019740;
      11: r = 37'sd7509872;
      12: r = 37'sd3754936;
      13: r = 37'sd1877468;
      14: r = 37'sd938734;
      15: r = 37'sd469367;
      16: r = 37'sd234684;
      17: r = 37'sd117342;
      18: r = 37'sd58671;
      19: r = 37'sd29335;
      20: r = 37'sd14668;
      21: r = 37'sd7334;
      22: r = 37'sd3667;
      23: r = 37'sd1833;
      24: r = 37'sd917;
      25: r = 37'sd458;
      26: r = 37'sd229;
      27: r = 37'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/sbot_wrap_cell.sv =====
// One conditional-subtract cell of the modulo-360 angle reduction chain.
module sbot_wrap_cell #(
  parameter int VW = 23,
  parameter int LW = 28,
  parameter int K  = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [VW-1:0]      v_i,
  input  logic [LW-1:0]      low_i,
  input  sbot_pkg::pay_t     pay_i,
  output logic               vld_o,
  output logic [VW-1:0]      v_o,
  output logic [LW-1:0]      low_o,
  output sbot_pkg::pay_t     pay_o
);
  import sbot_pkg::*;

  localparam logic [VW-1:0] Sub = {{(VW-9){1'b0}}, 9'd360} << K;

  logic [VW-1:0] v_d;

  // Remove 360 times 2^K when it fits.
  assign v_d = (v_i >= Sub) ? v_i - Sub : v_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_o   <= v_d;
      low_o <= low_i;
      pay_o <= pay_i;
    end
  end

endmodule

// ===== rtl/core/sbot_cordic_cell.sv =====
// One rotation-mode CORDIC iteration with its own pipeline register.
module sbot_cordic_cell #(
  parameter int I = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [33:0]   x_i,
  input  logic signed [33:0]   y_i,
  input  logic signed [36:0]   z_i,
  input  sbot_pkg::pay_t       pay_i,
  output logic                 vld_o,
  output logic signed [33:0]   x_o,
  output logic signed [33:0]   y_o,
  output logic signed [36:0]   z_o,
  output sbot_pkg::pay_t       pay_o
);
  import sbot_pkg::*;

  localparam logic signed [ZW-1:0] Atan = atan_q28(I);

  logic signed [XyW-1:0] xs, ys;

  // Floor shifts, then rotate toward zero residual angle.
  assign xs = x_i >>> I;
  assign ys = y_i >>> I;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (z_i >= 0) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - Atan;
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + Atan;
      end
      pay_o <= pay_i;
    end
  end

endmodule

// ===== rtl/core/sbot_div_cell.sv =====
// One restoring-division step that produces one quotient bit of 2^60 / cos.
module sbot_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [31:0]      rem_i,
  input  logic [30:0]      c_i,
  input  logic [42:0]      q_i,
  input  sbot_pkg::pay_t   pay_i,
  output logic             vld_o,
  output logic [31:0]      rem_o,
  output logic [30:0]      c_o,
  output logic [42:0]      q_o,
  output sbot_pkg::pay_t   pay_o
);
  import sbot_pkg::*;

  logic [31:0] rem2;
  logic        take;

  // The dividend bits below the leading one are all zero.
  assign rem2 = {rem_i[30:0], 1'b0};
  assign take = rem2 >= {1'b0, c_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= take ? rem2 - {1'b0, c_i} : rem2;
      c_o   <= c_i;
      q_o   <= {q_i[41:0], take};
      pay_o <= pay_i;
    end
  end

endmodule

// ===== rtl/core/sky_box_overlap_test.sv =====
// Top level of the sky box overlap test: point-in-trapezoid test with run OR.
//
// Input beats on s_axis carry one sky point and one box; s_axis_tlast marks
// the final point of an overlap query. Each input beat yields exactly one
// output beat on m_axis, in order: tdata bit 0 is the inside flag, bit 1 the
// OR of inside flags so far in the run, tuser flags a clipped 1/cos term,
// and tlast closes the run.
// Throughput is one point per cycle while the receiver keeps up. The pipeline
// holds a modulo-360 subtract chain, 28 CORDIC cells, 43
// divider cells for 1/cos, a split multiplier and the compare stage.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, s_axis_tready drops and every stage holds.
// Reset clears all stage valid bits, the output valid bit and the run OR.
module sky_box_overlap_test #(
  parameter int FRAC_BITS = 28
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // point_ra, point_dec, ref_ra, ref_dec, size_ra, size_dec, eq_ref_ra, eq_size_ra
  input  logic [319:0]  s_axis_tdata,
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // inside_res, overlap, then zero fill
  output logic [7:0]    m_axis_tdata,
  // saturated
  output logic          m_axis_tuser,
  output logic          m_axis_tlast
);
  import sbot_pkg::*;

  localparam int HW = 41 - FRAC_BITS;
  localparam int VW = HW + 10;
  localparam int NW = VW - 8;
  localparam longint Off = 360 * (((longint'(1) << (HW - 1)) + 359) / 360);

  logic en;

  // Field unpacking.
  logic signed [39:0] pr, pd, rr, rd, sr, sd, er, es;
  assign pr = s_axis_tdata[39:0];
  assign pd = s_axis_tdata[79:40];
  assign rr = s_axis_tdata[119:80];
  assign rd = s_axis_tdata[159:120];
  assign sr = s_axis_tdata[199:160];
  assign sd = s_axis_tdata[239:200];
  assign er = s_axis_tdata[279:240];
  assign es = s_axis_tdata[319:280];

  // Rule selection and cosine argument.
  logic signed [40:0] pd41, rd41, top;
  logic               south, north, eqr;
  pay_t               pay0_d;
  assign pd41  = 41'(pd);
  assign rd41  = 41'(rd);
  assign top   = rd41 + 41'(sd);
  assign south = pd <= 0;
  assign north = (rd != 0) && (top != 0) && (rd[39] == top[40]);
  assign eqr   = !south && !north;

  always_comb begin
    pay0_d        = '0;
    pay0_d.pr     = pr;
    pay0_d.base   = eqr ? er : rr;
    pay0_d.size   = eqr ? es : sr;
    pay0_d.south  = south;
    pay0_d.dec_ok = (pd41 >= rd41) && (pd41 <= top);
    pay0_d.last   = s_axis_tlast;
  end

  logic               v0_q;
  logic signed [40:0] ang_q;
  pay_t               pay0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q  <= eqr ? pd41 : pd41 - rd41;
      pay0_q <= pay0_d;
    end
  end

  // Whole-degree part made nonnegative by a multiple of 360.
  logic                 vw_c [NW+1];
  logic [VW-1:0]        v_c  [NW+1];
  logic [FRAC_BITS-1:0] low_c[NW+1];
  pay_t                 payw_c[NW+1];
  logic signed [40:0]   hi_s;
  assign hi_s = ang_q >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_c[0] <= 1'b0;
    end else if (en) begin
      vw_c[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_c[0]    <= VW'(hi_s) + VW'(Off);
      low_c[0]  <= ang_q[FRAC_BITS-1:0];
      payw_c[0] <= pay0_q;
    end
  end

  for (genvar j = 0; j < NW; j++) begin : g_wrap
    sbot_wrap_cell #(.VW(VW), .LW(FRAC_BITS), .K(NW - 1 - j)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(vw_c[j]), .v_i(v_c[j]), .low_i(low_c[j]), .pay_i(payw_c[j]),
      .vld_o(vw_c[j+1]), .v_o(v_c[j+1]), .low_o(low_c[j+1]), .pay_o(payw_c[j+1])
    );
  end

  // Fold into the first quadrant, noting a sign flip.
  logic [27:0]    frac28;
  logic [ZW-1:0]  z0, z1;
  logic           fneg;
  pay_t           payf_d;
  assign frac28 = 28'({low_c[NW], 28'b0} >> FRAC_BITS);
  assign z0     = {v_c[NW][8:0], frac28};
  assign z1     = (z0 > Deg180) ? Deg360 - z0 : z0;
  assign fneg   = z1 > Deg90;

  always_comb begin
    payf_d     = payw_c[NW];
    payf_d.neg = fneg;
  end

  logic                  vc_c [CordicSteps+1];
  logic signed [XyW-1:0] x_c  [CordicSteps+1];
  logic signed [XyW-1:0] y_c  [CordicSteps+1];
  logic signed [ZW-1:0]  z_c  [CordicSteps+1];
  pay_t                  payc_c[CordicSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_c[0] <= 1'b0;
    end else if (en) begin
      vc_c[0] <= vw_c[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_c[0]    <= XInit;
      y_c[0]    <= '0;
      z_c[0]    <= fneg ? signed'(Deg180 - z1) : signed'(z1);
      payc_c[0] <= payf_d;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    sbot_cordic_cell #(.I(i)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(vc_c[i]), .x_i(x_c[i]), .y_i(y_c[i]), .z_i(z_c[i]), .pay_i(payc_c[i]),
      .vld_o(vc_c[i+1]), .x_o(x_c[i+1]), .y_o(y_c[i+1]), .z_o(z_c[i+1]),
      .pay_o(payc_c[i+1])
    );
  end

  // Clamp, apply sign, and set up the divider.
  logic signed [XyW-1:0] xcl, cos34;
  logic signed [31:0]    cosv;
  pay_t                  payk_d;
  assign xcl   = (x_c[CordicSteps] > OneQ30) ? OneQ30 :
                 (x_c[CordicSteps] < -OneQ30) ? -OneQ30 : x_c[CordicSteps];
  assign cos34 = payc_c[CordicSteps].neg ? -xcl : xcl;
  assign cosv  = 32'(cos34);

  always_comb begin
    payk_d     = payc_c[CordicSteps];
    payk_d.fs  = 32'(OneQ30 - cos34);
    payk_d.sat = cosv < CosMin;
  end

  logic        vd_c  [DivSteps+1];
  logic [31:0] rem_c [DivSteps+1];
  logic [30:0] c_c   [DivSteps+1];
  logic [42:0] q_c   [DivSteps+1];
  pay_t        payd_c[DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_c[0] <= 1'b0;
    end else if (en) begin
      vd_c[0] <= vc_c[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_c[0]  <= RemInit;
      c_c[0]    <= cosv[30:0];
      q_c[0]    <= '0;
      payd_c[0] <= payk_d;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    sbot_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(vd_c[k]), .rem_i(rem_c[k]), .c_i(c_c[k]), .q_i(q_c[k]), .pay_i(payd_c[k]),
      .vld_o(vd_c[k+1]), .rem_o(rem_c[k+1]), .c_o(c_c[k+1]), .q_o(q_c[k+1]),
      .pay_o(payd_c[k+1])
    );
  end

  // Factor selection and magnitude of the width.
  pay_t          payp;
  logic [QW-1:0] f_d;
  assign payp = payd_c[DivSteps];
  assign f_d  = payp.south ? QW'(payp.fs) :
                payp.sat ? FSat : q_c[DivSteps] - OneQ;

  logic          vp_q, flip_q;
  logic [QW-1:0] f_q;
  logic [39:0]   m_q;
  pay_t          payp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= vd_c[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q    <= f_d;
      m_q    <= payp.size[39] ? 40'(-payp.size) : 40'(payp.size);
      flip_q <= payp.south ^ payp.size[39];
      payp_q <= payp;
    end
  end

  // Four partial products, then their sum.
  logic        vm_q, flipm_q;
  logic [41:0] p_hh_q, p_lh_q;
  logic [40:0] p_hl_q, p_ll_q;
  pay_t        paym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_hh_q  <= 42'(m_q[39:20] * f_q[42:21]);
      p_hl_q  <= 41'(m_q[39:20] * f_q[20:0]);
      p_lh_q  <= 42'(m_q[19:0] * f_q[42:21]);
      p_ll_q  <= 41'(m_q[19:0] * f_q[20:0]);
      flipm_q <= flip_q;
      paym_q  <= payp_q;
    end
  end

  logic [82:0] prod;
  logic [51:0] nmag;
  assign prod = (83'(p_hh_q) << 41) + (83'(p_hl_q) << 20) + (83'(p_lh_q) << 21)
              + 83'(p_ll_q);
  assign nmag = prod[82:31];

  logic               vs_q;
  logic signed [53:0] nn_q;
  pay_t               pays_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (en) begin
      vs_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nn_q   <= flipm_q ? -signed'(54'(nmag)) : signed'(54'(nmag));
      pays_q <= paym_q;
    end
  end

  // Bound compare and run accumulation into the output beat.
  logic signed [55:0] hi_b, lo_b, pr56;
  logic               in_box;
  assign pr56   = 56'(pays_q.pr);
  assign hi_b   = 56'(pays_q.base) + 56'(nn_q);
  assign lo_b   = 56'(pays_q.base) - 56'(pays_q.size) - 56'(nn_q);
  assign in_box = pays_q.dec_ok && (pr56 <= hi_b) && (pr56 >= lo_b);

  logic out_v_q, out_in_q, out_ovl_q, out_sat_q, out_last_q, run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      run_q   <= 1'b0;
    end else if (en) begin
      out_v_q <= vs_q;
      if (vs_q) begin
        run_q <= pays_q.last ? 1'b0 : (run_q | in_box);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_in_q   <= in_box;
      out_ovl_q  <= run_q | in_box;
      out_sat_q  <= pays_q.dec_ok && !pays_q.south && pays_q.sat;
      out_last_q <= pays_q.last;
    end
  end

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_ovl_q, out_in_q};
  assign m_axis_tuser  = out_sat_q;
  assign m_axis_tlast  = out_last_q;

  // An inside point always shows in the run OR.
  a_inside_ovl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (!out_in_q || out_ovl_q))
    else $error("inside flag without overlap");

  // A closing point clears the run state.
  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vs_q && pays_q.last) |=> !run_q)
    else $error("run state not cleared after last point");

  // A point leaving the last stage lands in the output register.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vs_q) |=> out_v_q)
    else $error("result lost at output");

  // A saturated or inside result needs a point inside the Dec range.
  a_sat_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vs_q && !pays_q.dec_ok) |=> !out_sat_q && !out_in_q)
    else $error("flags set outside Dec range");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the sky box overlap test: predicts every result beat.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Deg = longint'(1) <<< 28;
  localparam int IdleLimit = 5000;

  // One input point together with the box it is tested against.
  typedef struct {
    longint pr, pd, rr, rd, sr, sd, er, es;
    bit     last;
  } query_t;

  // One expected result beat.
  typedef struct {
    bit in_box, overlap, done, sat;
  } verdict_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [319:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  verdict_t verdict_q[$];
  bit       run_or;
  int       errors;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_req;
  int       hold_left;
  int       quiet_cycles;

  sky_box_overlap_test uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Cosine of an angle in degrees, Q30, by the same CORDIC the block uses.
  function automatic longint cos_deg(longint ang);
    longint full, m, z, x, y, xs, ys;
    bit neg;
    full = 360 * Deg;
    neg = 1'b0;
    m = ang % full;
    if (m < 0) m += full;
    z = m;
    if (z > 180 * Deg) z = 360 * Deg - z;
    if (z > 90 * Deg) begin
      neg = 1'b1;
      z = 180 * Deg - z;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < 28; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(sbot_pkg::atan_q28(i));
      end else begin
        x += ys; y -= xs; z += longint'(sbot_pkg::atan_q28(i));
      end
    end
    if (x > (longint'(1) <<< 30)) x = longint'(1) <<< 30;
    if (x < -(longint'(1) <<< 30)) x = -(longint'(1) <<< 30);
    return neg ? -x : x;
  endfunction

  // 1/cos - 1 in Q30, clipped when the cosine is too small.
  function automatic longint unsigned sec_minus_one(longint c, inout bit sat);
    if (c < (longint'(1) <<< 18)) begin
      sat = 1'b1;
      return (64'd1 << 42) - (64'd1 << 30);
    end
    return (64'd1 << 60) / longint'(c) - (64'd1 << 30);
  endfunction

  // a * f / 2^31, truncated toward zero in magnitude.
  function automatic longint half_product(longint a, longint unsigned f);
    longint unsigned mag, ah, al, hi, lo, res;
    mag = (a < 0) ? -a : a;
    ah = mag >> 21;
    al = mag & 64'h1FFFFF;
    hi = ah * f;
    lo = ((hi & 64'd1023) << 21) + al * f;
    res = (hi >> 10) + (lo >> 31);
    return (a < 0) ? -longint'(res) : longint'(res);
  endfunction

  // Expected result of one point, advancing the run OR.
  function automatic verdict_t judge_point(query_t q);
    verdict_t v;
    longint top, n;
    bit sat;
    sat = 1'b0;
    v.in_box = 1'b0;
    top = q.rd + q.sd;
    if (q.pd >= q.rd && q.pd <= top) begin
      if (q.pd <= 0) begin
        n = half_product(q.sr, (longint'(1) <<< 30) - cos_deg(q.pd - q.rd));
        v.in_box = (q.pr <= q.rr - n) && (q.pr >= q.rr - q.sr + n);
      end else if (q.rd != 0 && top != 0 && ((q.rd < 0) == (top < 0))) begin
        n = half_product(q.sr, sec_minus_one(cos_deg(q.pd - q.rd), sat));
        v.in_box = (q.pr <= q.rr + n) && (q.pr >= q.rr - q.sr - n);
      end else begin
        n = half_product(q.es, sec_minus_one(cos_deg(q.pd), sat));
        v.in_box = (q.pr <= q.er + n) && (q.pr >= q.er - q.es - n);
      end
    end
    v.overlap = run_or || v.in_box;
    run_or = q.last ? 1'b0 : v.overlap;
    v.done = q.last;
    v.sat = sat;
    return v;
  endfunction

  // Sign-extended random 40-bit value.
  function automatic longint any40();
    longint v;
    v = {$urandom, $urandom};
    return (v <<< 24) >>> 24;
  endfunction

  // Random angle with whole degrees in [lo, hi] and a random fraction.
  function automatic longint deg_range(int lo, int hi);
    return longint'(lo + int'($urandom_range(0, hi - lo))) * Deg
           + longint'($urandom_range(0, (1 << 28) - 1));
  endfunction

  // Send one point; the expectation is recorded on acceptance.
  task automatic send_point(query_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q.es[39:0], q.er[39:0], q.sd[39:0], q.sr[39:0],
                      q.rd[39:0], q.rr[39:0], q.pd[39:0], q.pr[39:0]};
    s_axis_tlast  <= q.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    verdict_q.push_back(judge_point(q));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // Box with a point near it; the rule follows from the declinations drawn.
  function automatic query_t near_point(query_t box);
    query_t q;
    q = box;
    q.pd = q.rd + ((q.sd > 0) ? longint'($urandom) % (q.sd + 1) : 0);
    if ($urandom_range(0, 9) == 0) q.pd = q.rd + q.sd + deg_range(-1, 1);
    q.pr = q.rr - q.sr / 2 + ((q.sr != 0) ? (any40() % q.sr) : 0);
    if (q.pd > 0 && $urandom_range(0, 1) == 1)
      q.pr = q.er - q.es / 2 + ((q.es != 0) ? (any40() % q.es) : 0);
    q.last = 1'b0;
    return q;
  endfunction

  function automatic query_t random_box();
    query_t b;
    b.rd = deg_range(-89, 80);
    b.sd = deg_range(0, 60);
    b.sr = deg_range(0, 40);
    if ($urandom_range(0, 9) == 0) b.sr = -b.sr;
    b.rr = deg_range(-360, 360);
    b.es = b.sr + deg_range(0, 5);
    b.er = b.rr + deg_range(-2, 2);
    return b;
  endfunction

  function automatic query_t noise_point();
    query_t q;
    q.pr = any40(); q.pd = any40(); q.rr = any40(); q.rd = any40();
    q.sr = any40(); q.sd = any40(); q.er = any40(); q.es = any40();
    q.last = $urandom_range(0, 1);
    return q;
  endfunction

  // Send overlap queries until roughly the given number of points went out.
  task automatic send_queries(int points);
    query_t box, q;
    int len, sent;
    sent = 0;
    while (sent < points) begin
      box = random_box();
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 8;
      for (int i = 0; i < len; i++) begin
        q = ($urandom_range(0, 6) == 0) ? noise_point() : near_point(box);
        q.last = (i == len - 1);
        send_point(q);
      end
      sent += len;
    end
  endtask

  // Extremes of every field, zero, and a lone single-point run.
  task automatic test_extremes();
    longint mx, mn;
    query_t q;
    mx = (longint'(1) <<< 39) - 1;
    mn = -(longint'(1) <<< 39);
    q = '{mx, mx, mx, mx, mx, mx, mx, mx, 1'b0};
    send_point(q);
    q = '{mn, mn, mn, mn, mn, mn, mn, mn, 1'b0};
    send_point(q);
    q = '{mn, mn, mx, mn, mx, mx, mx, mx, 1'b1};
    send_point(q);
    q = '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1};
    send_point(q);
    q = '{mx, 0, mx, mn, mn, mx, mn, mn, 1'b0};
    send_point(q);
    wait_drained();
  endtask

  // South, north and equator rules, pole clipping, reversed and wide boxes.
  task automatic test_rules();
    query_t q;
    // South box, point in the middle.
    q = '{10 * Deg - 5 * Deg, -40 * Deg, 10 * Deg, -50 * Deg, 10 * Deg,
          20 * Deg, 0, 0, 1'b0};
    send_point(q);
    // South box, point just outside the east edge.
    q.pr = 10 * Deg + 1;
    send_point(q);
    // North box, point inside.
    q = '{95 * Deg, 50 * Deg, 100 * Deg, 40 * Deg, 10 * Deg,
          20 * Deg, 0, 0, 1'b1};
    send_point(q);
    // Equator-crossing box uses the equator equivalents.
    q = '{30 * Deg, 5 * Deg, 200 * Deg, -10 * Deg, 10 * Deg, 30 * Deg,
          35 * Deg, 10 * Deg, 1'b0};
    send_point(q);
    // Box starting on the equator.
    q = '{30 * Deg, 5 * Deg, 200 * Deg, 0, 10 * Deg, 30 * Deg,
          35 * Deg, 10 * Deg, 1'b1};
    send_point(q);
    // Pole: cosine reaches zero, the 1/cos term clips.
    q = '{100 * Deg, 90 * Deg, 100 * Deg, 0 + 1, 10 * Deg, 100 * Deg,
          0, 0, 1'b0};
    send_point(q);
    q = '{100 * Deg, 95 * Deg, 100 * Deg, 5 * Deg, 10 * Deg, 100 * Deg,
          0, 0, 1'b0};
    send_point(q);
    // Cosine below the clip threshold in the equator rule.
    q = '{0, 90 * Deg - 2000, 0, -1 * Deg, 5 * Deg, 100 * Deg,
          0, 5 * Deg, 1'b1};
    send_point(q);
    // Negative sizes and a reversed declination range.
    q = '{20 * Deg, 30 * Deg, 10 * Deg, 20 * Deg, -10 * Deg, 20 * Deg,
          0, 0, 1'b0};
    send_point(q);
    q = '{20 * Deg, 30 * Deg, 10 * Deg, 40 * Deg, 10 * Deg, -20 * Deg,
          0, 0, 1'b0};
    send_point(q);
    // Wide box: cosine argument well beyond a full turn.
    q = '{-300 * Deg, 700 * Deg, -290 * Deg, -400 * Deg, 20 * Deg,
          1200 * Deg, -280 * Deg, -30 * Deg, 1'b1};
    send_point(q);
    // Point below the declination range.
    q = '{0, -60 * Deg, 0, -50 * Deg, 10 * Deg, 20 * Deg, 0, 0, 1'b1};
    send_point(q);
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering points.
  task automatic test_backpressure();
    hold_req = 400;
    send_queries(200);
    wait_drained();
  endtask

  task automatic test_random(int send_pct, int recv_pct, int points);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    send_queries(points);
    wait_drained();
  endtask

  // Receiver: random stalls, or a long hold when one is requested.
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected beat: inside=%0b overlap=%0b last=%0b sat=%0b",
                 $time, m_axis_tdata[0], m_axis_tdata[1], m_axis_tlast,
                 m_axis_tuser);
        errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (m_axis_tdata[0] !== exp_v.in_box) begin
          $display("%0t: inside expected %0b actual %0b", $time, exp_v.in_box,
                   m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[1] !== exp_v.overlap) begin
          $display("%0t: overlap expected %0b actual %0b", $time, exp_v.overlap,
                   m_axis_tdata[1]);
          errors++;
        end
        if (m_axis_tlast !== exp_v.done) begin
          $display("%0t: run end expected %0b actual %0b", $time, exp_v.done,
                   m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== exp_v.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, exp_v.sat,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else if (rst_ni)
      quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    run_or = 1'b0;
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_rules();
    test_random(35, 61, 350);
    test_random(61, 35, 350);
    test_backpressure();
    test_random(0, 0, 250);

    repeat (200) @(posedge clk_i);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sbot_pkg.sv
rtl/core/sbot_wrap_cell.sv
rtl/core/sbot_cordic_cell.sv
rtl/core/sbot_div_cell.sv
rtl/core/sky_box_overlap_test.sv
verif/testbench.sv
